>>> rtl/es2c_pkg.sv
// Package for the epoch-seconds to calendar converter: shared constants and types.
// Depends on nothing; every rtl file refers to it by scoped names.
package es2c_pkg;

    // 86400 = 675 * 2^7, so the day split is a shift followed by a divide by 675.
    localparam int unsigned SECS_LOW_BITS = 7;
    localparam logic [9:0]  DAY_SECS_ODD  = 10'd675;
    localparam int unsigned DAY_REM_WIDTH = 11;
    localparam int unsigned TOD_WIDTH     = 17;

    // Pipeline depth of the date path, which the time-of-day path matches.
    localparam int unsigned DATE_STAGES = 10;

    // Reciprocals are floor(2^FRAC / divisor), each followed by one correction step.
    localparam logic [5:0]  SECS_PER_MIN = 6'd60;
    localparam int unsigned TOD_FRAC     = 17;
    localparam logic [11:0] RECIP_60_TOD = 12'd2184;
    localparam int unsigned MIN_FRAC     = 11;
    localparam logic [5:0]  RECIP_60_MIN = 6'd34;

    localparam logic [19:0] MARCH_ERA_SHIFT  = 20'd719468;
    localparam logic [17:0] DAYS_PER_ERA     = 18'd146097;
    localparam logic [17:0] LAST_DAY_OF_ERA  = 18'd146096;
    localparam logic [2:0]  EPOCH_WEEKDAY    = 3'd4;
    localparam logic [2:0]  DAYS_PER_WEEK    = 3'd7;

    localparam int unsigned DOE_FRAC      = 18;
    localparam logic [7:0]  RECIP_1460    = 8'd179;
    localparam logic [10:0] DAYS_PER_4Y   = 11'd1460;
    localparam logic [2:0]  RECIP_36524   = 3'd7;
    localparam logic [15:0] DAYS_PER_CENT = 16'd36524;
    localparam logic [9:0]  RECIP_365     = 10'd718;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

    localparam logic [8:0]  YEARS_PER_CENT = 9'd100;
    localparam logic [8:0]  YEARS_PER_ERA  = 9'd400;
    localparam logic [10:0] YEAR_BASE      = 11'd1900;
    localparam logic [8:0]  MARCH_TO_JAN   = 9'd306;
    localparam logic [8:0]  DAYS_JAN_FEB   = 9'd59;

    typedef logic [3:0] month_t;
    typedef logic [8:0] doy_t;

    localparam month_t JANUARY       = 4'd0;
    localparam month_t MONTH_MARCH   = 4'd2;
    localparam month_t MP_YEAR_WRAP  = 4'd10;
    localparam month_t MARCH_MONTHS  = 4'd12;

    // First day of each month, counted from March 1 of a March-based year.
    localparam doy_t MARCH_START [12] = '{
        9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

endpackage

>>> rtl/epoch_seconds_to_calendar.sv
// Top level of the epoch-seconds to UTC calendar converter.
// Depends on es2c_pkg, es2c_tod and es2c_date.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-----------------------------------------------
//  input    | start, busy        | epoch_seconds
//  result   | done (one cycle)   | second_of_minute, minute_of_hour, hour_of_day,
//           |                    | day_of_week, years_since_1900, day_of_year,
//           |                    | month_index, day_of_month
//
// A word is taken at every clock edge where start is high; busy never rises, so
// one word per cycle is sustained. Each result appears on done once its word has
// passed the day-split stages and the date pipeline, whose reciprocal-multiply and
// correction stages derive the year of era. The receiver cannot stall the result
// side, and nothing in the pipeline ever waits. Reset clears only the valid bits.
module epoch_seconds_to_calendar #(
    parameter int unsigned SECONDS_WIDTH = 36
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [SECONDS_WIDTH-1:0] epoch_seconds,
    output logic                     done,
    output logic [5:0]               second_of_minute,
    output logic [5:0]               minute_of_hour,
    output logic [4:0]               hour_of_day,
    output logic [2:0]               day_of_week,
    output logic [11:0]              years_since_1900,
    output logic [8:0]               day_of_year,
    output logic [3:0]               month_index,
    output logic [4:0]               day_of_month
);

    // The low seven bits of the seconds bypass the divide, since 86400 = 675 * 128.
    // XW is the width of the part divided by 675; the day count fits in DW bits.
    localparam int unsigned LOW     = es2c_pkg::SECS_LOW_BITS;
    localparam int unsigned XW      = SECONDS_WIDTH - LOW;
    localparam int unsigned DW      = SECONDS_WIDTH - 16;
    localparam int unsigned PW      = XW + DW;
    localparam int unsigned RW      = es2c_pkg::DAY_REM_WIDTH;
    localparam int unsigned LATENCY = 3 + es2c_pkg::DATE_STAGES;

    // floor(2^XW / 675); the quotient estimate is then low by at most one.
    localparam logic [DW-1:0] RECIP_DAY = DW'((64'd1 << XW) / 64'd675);

    logic            v1_reg, v2_reg, v3_reg;
    logic            accept;

    // Stage 1: reciprocal product of the high part of the seconds.
    logic [PW-1:0]   prod1_reg, prod1_next;
    logic [XW-1:0]   hi1_reg;
    logic [LOW-1:0]  lo1_reg;

    // Stage 2: day estimate and the remainder it leaves.
    logic [DW-1:0]   qe2_reg, qe2_next;
    logic [RW-1:0]   r2_reg, r2_next;
    logic [LOW-1:0]  lo2_reg;

    // Stage 3: corrected day count and seconds within the day.
    logic [DW-1:0]                    days3_reg, days3_next;
    logic [es2c_pkg::TOD_WIDTH-1:0]   secs3_reg, secs3_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        logic [XW-1:0] rdiff;
        logic [RW-1:0] rfix;
        prod1_next = PW'(epoch_seconds[SECONDS_WIDTH-1:LOW]) * PW'(RECIP_DAY);

        qe2_next = prod1_reg[PW-1:XW];
        rdiff    = hi1_reg - XW'(XW'(qe2_next) * XW'(es2c_pkg::DAY_SECS_ODD));
        r2_next  = rdiff[RW-1:0];

        if (r2_reg >= RW'(es2c_pkg::DAY_SECS_ODD))
        begin
            days3_next = qe2_reg + DW'(1);
            rfix       = r2_reg - RW'(es2c_pkg::DAY_SECS_ODD);
        end
        else
        begin
            days3_next = qe2_reg;
            rfix       = r2_reg;
        end
        secs3_next = {rfix[es2c_pkg::TOD_WIDTH-LOW-1:0], lo2_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod1_reg <= prod1_next;
        hi1_reg   <= epoch_seconds[SECONDS_WIDTH-1:LOW];
        lo1_reg   <= epoch_seconds[LOW-1:0];
        qe2_reg   <= qe2_next;
        r2_reg    <= r2_next;
        lo2_reg   <= lo1_reg;
        days3_reg <= days3_next;
        secs3_reg <= secs3_next;
    end

    // Time of day and calendar date run side by side with equal latency.
    es2c_tod u_tod (
        .clk              (clk),
        .day_secs         (secs3_reg),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute)
    );

    es2c_date #(
        .DAYS_WIDTH (DW)
    ) u_date (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (v3_reg),
        .days             (days3_reg),
        .out_valid        (done),
        .day_of_week      (day_of_week),
        .years_since_1900 (years_since_1900),
        .day_of_year      (day_of_year),
        .month_index      (month_index),
        .day_of_month     (day_of_month)
    );

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted word produced no result at the expected cycle");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without a matching accepted word");

    a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (second_of_minute < 6'd60) && (minute_of_hour < 6'd60)
                 && (hour_of_day < 5'd24))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (month_index <= 4'd11) && (day_of_month != 5'd0)
                 && (day_of_year <= 9'd365) && (day_of_week <= 3'd6))
        else $error("calendar field out of range");

    a_january: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (month_index == es2c_pkg::JANUARY))
            |-> (day_of_year == (9'(day_of_month) - 9'd1)))
        else $error("January day of year disagrees with day of month");
`endif

endmodule

>>> rtl/es2c_tod.sv
// Time-of-day splitter: seconds within a day into hour, minute and second.
// Depends on es2c_pkg; its latency matches the date path (DATE_STAGES).
module es2c_tod (
    input  logic                             clk,
    input  logic [es2c_pkg::TOD_WIDTH-1:0]   day_secs,
    output logic [4:0]                       hour_of_day,
    output logic [5:0]                       minute_of_hour,
    output logic [5:0]                       second_of_minute
);

    localparam int unsigned PMW = es2c_pkg::TOD_WIDTH + 12;
    localparam int unsigned PHW = 11 + 6;
    localparam int unsigned PAD = es2c_pkg::DATE_STAGES - 4;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    logic [PMW-1:0]                     pm_reg, pm_next;
    logic [es2c_pkg::TOD_WIDTH-1:0]     secs1_reg;
    logic [10:0]                        mq_reg, mq_next;
    logic [6:0]                         mr_reg, mr_next;
    logic [10:0]                        mins_reg, mins_next;
    logic [5:0]                         sec3_reg, sec3_next;
    logic [PHW-1:0]                     ph_reg, ph_next;
    logic [4:0]                         hq_reg, hq_next;
    logic [6:0]                         hr_reg, hr_next;
    logic [5:0]                         sec4_reg;
    tod_t                               tod_next;
    tod_t                               pad_reg [PAD];

    always_comb
    begin
        logic [es2c_pkg::TOD_WIDTH-1:0] sdiff;
        logic [10:0]                    mdiff;
        pm_next = PMW'(day_secs) * PMW'(es2c_pkg::RECIP_60_TOD);

        mq_next = pm_reg[es2c_pkg::TOD_FRAC + 10:es2c_pkg::TOD_FRAC];
        sdiff   = secs1_reg - es2c_pkg::TOD_WIDTH'(
                  es2c_pkg::TOD_WIDTH'(mq_next) * es2c_pkg::TOD_WIDTH'(es2c_pkg::SECS_PER_MIN));
        mr_next = sdiff[6:0];

        // The estimate is low by at most one minute.
        if (mr_reg >= 7'(es2c_pkg::SECS_PER_MIN))
        begin
            mins_next = mq_reg + 11'd1;
            sec3_next = 6'(mr_reg - 7'(es2c_pkg::SECS_PER_MIN));
        end
        else
        begin
            mins_next = mq_reg;
            sec3_next = mr_reg[5:0];
        end
        ph_next = PHW'(mins_next) * PHW'(es2c_pkg::RECIP_60_MIN);

        hq_next = ph_reg[es2c_pkg::MIN_FRAC + 4:es2c_pkg::MIN_FRAC];
        mdiff   = mins_reg - 11'(11'(hq_next) * 11'(es2c_pkg::SECS_PER_MIN));
        hr_next = mdiff[6:0];

        if (hr_reg >= 7'(es2c_pkg::SECS_PER_MIN))
        begin
            tod_next.hour   = hq_reg + 5'd1;
            tod_next.minute = 6'(hr_reg - 7'(es2c_pkg::SECS_PER_MIN));
        end
        else
        begin
            tod_next.hour   = hq_reg;
            tod_next.minute = hr_reg[5:0];
        end
        tod_next.second = sec4_reg;
    end

    always_ff @(posedge clk)
    begin
        pm_reg    <= pm_next;
        secs1_reg <= day_secs;
        mq_reg    <= mq_next;
        mr_reg    <= mr_next;
        mins_reg  <= mins_next;
        sec3_reg  <= sec3_next;
        ph_reg    <= ph_next;
        hq_reg    <= hq_next;
        hr_reg    <= hr_next;
        sec4_reg  <= sec3_reg;
        pad_reg[0] <= tod_next;
        for (int i = 1; i < PAD; i++)
        begin
            pad_reg[i] <= pad_reg[i-1];
        end
    end

    assign hour_of_day      = pad_reg[PAD-1].hour;
    assign minute_of_hour   = pad_reg[PAD-1].minute;
    assign second_of_minute = pad_reg[PAD-1].second;

endmodule

>>> rtl/es2c_date.sv
// Civil date pipeline: day count since the epoch into weekday and Gregorian date.
// Depends on es2c_pkg, whose DATE_STAGES also sizes the valid pipeline.
module es2c_date #(
    parameter int unsigned DAYS_WIDTH = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [DAYS_WIDTH-1:0] days,
    output logic                  out_valid,
    output logic [2:0]            day_of_week,
    output logic [11:0]           years_since_1900,
    output logic [8:0]            day_of_year,
    output logic [3:0]            month_index,
    output logic [4:0]            day_of_month
);

    // The shifted day count must hold the March era offset even for narrow day counts.
    localparam int unsigned ZW  = ((DAYS_WIDTH > 20) ? DAYS_WIDTH : 20) + 1;
    localparam int unsigned EW  = ZW - 17;
    localparam int unsigned WW  = ZW - 2;
    localparam int unsigned YW  = EW + 10;
    localparam int unsigned PEW = ZW + EW;
    localparam int unsigned PWW = ZW + WW;
    localparam int unsigned NS  = es2c_pkg::DATE_STAGES;
    localparam logic [EW-1:0] RECIP_ERA  = EW'((64'd1 << ZW) / 64'd146097);
    localparam logic [WW-1:0] RECIP_WEEK = WW'((64'd1 << ZW) / 64'd7);
    localparam logic [8:0] CENT2 = 9'(2 * es2c_pkg::YEARS_PER_CENT);
    localparam logic [8:0] CENT3 = 9'(3 * es2c_pkg::YEARS_PER_CENT);

    logic [NS-1:0] vld_reg;

    // stage 1
    logic [ZW-1:0]  z1_reg, z1_next, w1_reg, w1_next;
    logic [PEW-1:0] pe1_reg, pe1_next;
    logic [PWW-1:0] pw1_reg, pw1_next;
    // stage 2
    logic [EW-1:0]  era2_reg, era2_next;
    logic [18:0]    doe2_reg, doe2_next;
    logic [3:0]     wr2_reg, wr2_next;
    // stage 3
    logic [EW-1:0]  era3_reg, era3_next;
    logic [17:0]    doe3_reg, doe3_next;
    logic [2:0]     wd3_reg, wd3_next;
    logic [25:0]    pa3_reg, pa3_next;
    logic [20:0]    pb3_reg, pb3_next;
    // stage 4
    logic [6:0]     ae4_reg, ae4_next;
    logic [11:0]    ar4_reg, ar4_next;
    logic [2:0]     be4_reg, be4_next;
    logic [16:0]    br4_reg, br4_next;
    logic [17:0]    doe4_reg;
    // stage 5
    logic [17:0]    n5_reg, n5_next;
    logic [17:0]    doe5_reg;
    // stage 6
    logic [27:0]    pn6_reg, pn6_next;
    logic [17:0]    n6_reg, doe6_reg;
    // stage 7
    logic [8:0]     ye7_reg, ye7_next;
    logic [9:0]     yr7_reg, yr7_next;
    logic [17:0]    doe7_reg;
    // stage 8
    logic [8:0]     yoe8_reg, yoe8_next;
    logic [17:0]    doe8_reg;
    // stage 9
    logic [8:0]     doy9_reg, doy9_next;
    logic           leap9_reg, leap9_next;
    logic [YW-1:0]  yb9_reg, yb9_next;
    // carried era, stages 4 through 8, and weekday, stages 4 through 9
    logic [EW-1:0]  era_c_reg [4:8];
    logic [2:0]     wd_c_reg  [4:9];
    // outputs
    logic [2:0]     wd_out_reg;
    logic [11:0]    year_out_reg, year_out_next;
    logic [8:0]     yday_out_reg, yday_out_next;
    es2c_pkg::month_t mon_out_reg, mon_out_next;
    logic [4:0]     mday_out_reg, mday_out_next;

    always_comb
    begin
        logic [ZW-1:0]   zdiff, wdiff;
        logic [17:0]     adiff, bdiff, ydiff, acc;
        logic [1:0]      c100;
        logic            cent_exact;
        es2c_pkg::month_t mp;
        logic [8:0]      mdiff;
        logic [YW-1:0]   year_full;

        // Stage 1: shift to the March-based era and start both reciprocal multiplies.
        z1_next  = ZW'(days) + ZW'(es2c_pkg::MARCH_ERA_SHIFT);
        w1_next  = ZW'(days) + ZW'(es2c_pkg::EPOCH_WEEKDAY);
        pe1_next = PEW'(z1_next) * PEW'(RECIP_ERA);
        pw1_next = PWW'(w1_next) * PWW'(RECIP_WEEK);

        // Stage 2: quotient estimates and their remainders.
        era2_next = pe1_reg[PEW-1:ZW];
        zdiff     = z1_reg - ZW'(ZW'(era2_next) * ZW'(es2c_pkg::DAYS_PER_ERA));
        doe2_next = zdiff[18:0];
        wdiff     = w1_reg - ZW'(ZW'(pw1_reg[PWW-1:ZW]) * ZW'(es2c_pkg::DAYS_PER_WEEK));
        wr2_next  = wdiff[3:0];

        // Stage 3: correct era and weekday, then estimate the 4-year and century counts.
        if (doe2_reg >= 19'(es2c_pkg::DAYS_PER_ERA))
        begin
            era3_next = era2_reg + EW'(1);
            doe3_next = 18'(doe2_reg - 19'(es2c_pkg::DAYS_PER_ERA));
        end
        else
        begin
            era3_next = era2_reg;
            doe3_next = doe2_reg[17:0];
        end
        wd3_next = (wr2_reg >= 4'(es2c_pkg::DAYS_PER_WEEK))
                 ? 3'(wr2_reg - 4'(es2c_pkg::DAYS_PER_WEEK)) : wr2_reg[2:0];
        pa3_next = 26'(doe3_next) * 26'(es2c_pkg::RECIP_1460);
        pb3_next = 21'(doe3_next) * 21'(es2c_pkg::RECIP_36524);

        // Stage 4
        ae4_next = pa3_reg[es2c_pkg::DOE_FRAC + 6:es2c_pkg::DOE_FRAC];
        adiff    = doe3_reg - 18'(18'(ae4_next) * 18'(es2c_pkg::DAYS_PER_4Y));
        ar4_next = adiff[11:0];
        be4_next = pb3_reg[es2c_pkg::DOE_FRAC + 2:es2c_pkg::DOE_FRAC];
        bdiff    = doe3_reg - 18'(18'(be4_next) * 18'(es2c_pkg::DAYS_PER_CENT));
        br4_next = bdiff[16:0];

        // Stage 5: day of era with the leap days folded out.
        n5_next = doe4_reg
                - 18'(ae4_reg + 7'(ar4_reg >= 12'(es2c_pkg::DAYS_PER_4Y)))
                + 18'(be4_reg + 3'(br4_reg >= 17'(es2c_pkg::DAYS_PER_CENT)))
                - 18'(doe4_reg == es2c_pkg::LAST_DAY_OF_ERA);

        // Stage 6
        pn6_next = 28'(n5_reg) * 28'(es2c_pkg::RECIP_365);

        // Stage 7
        ye7_next = pn6_reg[es2c_pkg::DOE_FRAC + 8:es2c_pkg::DOE_FRAC];
        ydiff    = n6_reg - 18'(18'(ye7_next) * 18'(es2c_pkg::DAYS_PER_YEAR));
        yr7_next = ydiff[9:0];

        // Stage 8
        yoe8_next = ye7_reg + 9'(yr7_reg >= 10'(es2c_pkg::DAYS_PER_YEAR));

        // Stage 9: day within the March-based year, leap flag and base year.
        c100 = 2'(yoe8_reg >= es2c_pkg::YEARS_PER_CENT) + 2'(yoe8_reg >= CENT2)
             + 2'(yoe8_reg >= CENT3);
        acc  = 18'(18'(yoe8_reg) * 18'(es2c_pkg::DAYS_PER_YEAR))
             + 18'(yoe8_reg[8:2]) - 18'(c100);
        doy9_next  = 9'(doe8_reg - acc);
        cent_exact = (yoe8_reg == es2c_pkg::YEARS_PER_CENT) || (yoe8_reg == CENT2)
                  || (yoe8_reg == CENT3);
        // Within an era the year modulo 400 is the year of era itself.
        leap9_next = (yoe8_reg[1:0] == 2'b00) && !cent_exact;
        yb9_next   = YW'(YW'(era_c_reg[8]) * YW'(es2c_pkg::YEARS_PER_ERA)) + YW'(yoe8_reg);

        // Stage 10: month lookup and calendar fields.
        mp = '0;
        for (int i = 1; i < 12; i++)
        begin
            mp = mp + es2c_pkg::month_t'(doy9_reg >= es2c_pkg::MARCH_START[i]);
        end
        mdiff         = doy9_reg - es2c_pkg::MARCH_START[mp] + 9'd1;
        mday_out_next = mdiff[4:0];
        if (mp < es2c_pkg::MP_YEAR_WRAP)
        begin
            mon_out_next  = mp + es2c_pkg::MONTH_MARCH;
            year_full     = yb9_reg;
            yday_out_next = doy9_reg + es2c_pkg::DAYS_JAN_FEB + 9'(leap9_reg);
        end
        else
        begin
            mon_out_next  = mp + es2c_pkg::MONTH_MARCH - es2c_pkg::MARCH_MONTHS;
            year_full     = yb9_reg + YW'(1);
            yday_out_next = doy9_reg - es2c_pkg::MARCH_TO_JAN;
        end
        year_out_next = 12'(year_full - YW'(es2c_pkg::YEAR_BASE));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        z1_reg   <= z1_next;
        w1_reg   <= w1_next;
        pe1_reg  <= pe1_next;
        pw1_reg  <= pw1_next;
        era2_reg <= era2_next;
        doe2_reg <= doe2_next;
        wr2_reg  <= wr2_next;
        era3_reg <= era3_next;
        doe3_reg <= doe3_next;
        wd3_reg  <= wd3_next;
        pa3_reg  <= pa3_next;
        pb3_reg  <= pb3_next;
        ae4_reg  <= ae4_next;
        ar4_reg  <= ar4_next;
        be4_reg  <= be4_next;
        br4_reg  <= br4_next;
        doe4_reg <= doe3_reg;
        n5_reg   <= n5_next;
        doe5_reg <= doe4_reg;
        pn6_reg  <= pn6_next;
        n6_reg   <= n5_reg;
        doe6_reg <= doe5_reg;
        ye7_reg  <= ye7_next;
        yr7_reg  <= yr7_next;
        doe7_reg <= doe6_reg;
        yoe8_reg <= yoe8_next;
        doe8_reg <= doe7_reg;
        doy9_reg  <= doy9_next;
        leap9_reg <= leap9_next;
        yb9_reg   <= yb9_next;
        era_c_reg[4] <= era3_reg;
        wd_c_reg[4]  <= wd3_reg;
        for (int i = 5; i <= 8; i++)
        begin
            era_c_reg[i] <= era_c_reg[i-1];
        end
        for (int i = 5; i <= 9; i++)
        begin
            wd_c_reg[i] <= wd_c_reg[i-1];
        end
        wd_out_reg   <= wd_c_reg[9];
        year_out_reg <= year_out_next;
        yday_out_reg <= yday_out_next;
        mon_out_reg  <= mon_out_next;
        mday_out_reg <= mday_out_next;
    end

    assign out_valid        = vld_reg[NS-1];
    assign day_of_week      = wd_out_reg;
    assign years_since_1900 = year_out_reg;
    assign day_of_year      = yday_out_reg;
    assign month_index      = mon_out_reg;
    assign day_of_month     = mday_out_reg;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for epoch_seconds_to_calendar, the epoch-seconds to UTC date converter.
// Depends on es2c_pkg for the month and day-of-year types and on the RTL of the converter.

module tb;

    // The converter is built at its default input width.
    localparam int unsigned STAMP_WIDTH = 36;

    // Results trail their word through the pipeline; a little slack is added after the
    // last one so that a stray extra result is still seen.
    localparam int unsigned SETTLE_CYCLES = 20;

    // The longest sender gap plus a full drain falls far short of HANG_LIMIT, so a
    // stretch that long with no handshake at all can only mean a hang.
    localparam int unsigned HANG_LIMIT = 1000;

    localparam int unsigned RANDOM_WORDS = 1025;
    localparam int unsigned SHOWN_FAULTS = 10;

    localparam longint unsigned SECS_IN_DAY  = 86400;
    localparam longint unsigned SECS_IN_HOUR = 3600;
    localparam longint unsigned SECS_IN_MIN  = 60;
    localparam longint unsigned DAY_COUNT_MAX = (64'd1 << STAMP_WIDTH) / SECS_IN_DAY;

    // One broken-down UTC time, laid out as the result ports are.
    typedef struct packed {
        logic [5:0]      second;
        logic [5:0]      minute;
        logic [4:0]      hour;
        logic [2:0]      weekday;
        logic [11:0]     year_off;
        es2c_pkg::doy_t  yday;
        es2c_pkg::month_t month;
        logic [4:0]      mday;
    } utc_date_t;

    // A word waiting to be sent. A hold word is only sent once every date
    // already in flight has come back; a quiet word is followed by no gap.
    typedef struct packed {
        logic [STAMP_WIDTH-1:0] stamp;
        logic                   hold;
        logic                   quiet;
    } stamp_word_t;

    typedef struct packed {
        logic [STAMP_WIDTH-1:0] stamp;
        utc_date_t              date;
    } dated_stamp_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [STAMP_WIDTH-1:0] epoch_seconds;
    logic                   done;
    logic [5:0]             second_of_minute;
    logic [5:0]             minute_of_hour;
    logic [4:0]             hour_of_day;
    logic [2:0]             day_of_week;
    logic [11:0]            years_since_1900;
    logic [8:0]             day_of_year;
    logic [3:0]             month_index;
    logic [4:0]             day_of_month;

    stamp_word_t  stamps_waiting[$];
    dated_stamp_t dates_due[$];

    int unsigned gap_left;
    int unsigned fault_count;
    int unsigned hang_count;

    epoch_seconds_to_calendar #(
        .SECONDS_WIDTH(STAMP_WIDTH)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .epoch_seconds   (epoch_seconds),
        .done            (done),
        .second_of_minute(second_of_minute),
        .minute_of_hour  (minute_of_hour),
        .hour_of_day     (hour_of_day),
        .day_of_week     (day_of_week),
        .years_since_1900(years_since_1900),
        .day_of_year     (day_of_year),
        .month_index     (month_index),
        .day_of_month    (day_of_month)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Gregorian rule: every fourth year, except centuries not divisible by 400.
    function automatic bit is_leap(longint unsigned year);
        return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    endfunction

    // Expected calendar date for a timestamp. The date is found in a year that
    // starts on March 1, which puts the leap day at the very end; the Gregorian
    // calendar repeats exactly every 400 years, so only the day within one era
    // needs the uneven year lengths. The era origin is 0000-03-01.
    function automatic utc_date_t calendar_of(logic [STAMP_WIDTH-1:0] stamp);
        longint unsigned secs;
        longint unsigned days;
        longint unsigned tod;
        longint unsigned since_origin;
        longint unsigned cycle;
        longint unsigned day_in_cycle;
        longint unsigned year_in_cycle;
        longint unsigned march_day;
        longint unsigned march_month;
        longint unsigned month;
        longint unsigned year;
        longint unsigned mday;
        longint unsigned yday;
        utc_date_t       d;
        secs = longint'(stamp);
        days = secs / SECS_IN_DAY;
        tod  = secs % SECS_IN_DAY;

        // Day 0 of the epoch is 719468 days after the origin.
        since_origin  = days + 719468;
        cycle         = since_origin / 146097;
        day_in_cycle  = since_origin % 146097;
        // Take out one day per four years, put back one per century and take
        // out the last day of the cycle, so that every year is 365 days long.
        year_in_cycle = (day_in_cycle - day_in_cycle / 1460 + day_in_cycle / 36524
                         - day_in_cycle / 146096) / 365;
        march_day     = day_in_cycle - (365 * year_in_cycle + year_in_cycle / 4
                                        - year_in_cycle / 100);
        // Months from March run 31, 30, 31, 30, 31 in a five-month pattern.
        march_month   = (5 * march_day + 2) / 153;
        mday          = march_day - (153 * march_month + 2) / 5 + 1;
        month         = (march_month < 10) ? march_month + 2 : march_month - 10;
        year          = cycle * 400 + year_in_cycle + ((month < 2) ? 1 : 0);

        // January and February close the March-based year: 306 days precede them.
        if (month < 2)
        begin
            yday = march_day - 306;
        end
        else
        begin
            yday = march_day + 59 + (is_leap(year) ? 1 : 0);
        end

        d.second   = 6'(tod % SECS_IN_MIN);
        d.minute   = 6'((tod % SECS_IN_HOUR) / SECS_IN_MIN);
        d.hour     = 5'(tod / SECS_IN_HOUR);
        // The epoch fell on a Thursday.
        d.weekday  = 3'((days + 4) % 7);
        d.year_off = 12'(year - 1900);
        d.yday     = 9'(yday);
        d.month    = 4'(month);
        d.mday     = 5'(mday);
        return d;
    endfunction

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic string show_date(utc_date_t d);
        return $sformatf("%0d-%0d-%0d %0d:%0d:%0d wd%0d yd%0d", d.year_off, d.month, d.mday,
                         d.hour, d.minute, d.second, d.weekday, d.yday);
    endfunction

    // Driver. A word presented on the previous cycle is taken at this edge if
    // busy was low; its date is predicted right away. Then the next word, a
    // gap, or a hold for an empty pipeline is chosen for the cycle to come.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start         <= 1'b0;
            epoch_seconds <= '0;
            gap_left      <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                dates_due.push_back('{stamp: epoch_seconds, date: calendar_of(epoch_seconds)});
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end
                else if (stamps_waiting.size() > 0 &&
                         !(stamps_waiting[0].hold && dates_due.size() > 0))
                begin
                    start         <= 1'b1;
                    epoch_seconds <= stamps_waiting[0].stamp;
                    gap_left      <= stamps_waiting[0].quiet ? 0 : draw_gap();
                    void'(stamps_waiting.pop_front());
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor. The strobe lasts one cycle and cannot be held off, so every
    // cycle with done high is a result that must match the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (dates_due.size() == 0)
            begin
                if (fault_count < SHOWN_FAULTS)
                begin
                    $display("unexpected result at %0t: %s", $realtime,
                             show_date({second_of_minute, minute_of_hour, hour_of_day,
                                        day_of_week, years_since_1900, day_of_year,
                                        month_index, day_of_month}));
                end
                fault_count <= fault_count + 1;
            end
            else
            begin
                if (dates_due[0].date.second   !== second_of_minute ||
                    dates_due[0].date.minute   !== minute_of_hour   ||
                    dates_due[0].date.hour     !== hour_of_day      ||
                    dates_due[0].date.weekday  !== day_of_week      ||
                    dates_due[0].date.year_off !== years_since_1900 ||
                    dates_due[0].date.yday     !== day_of_year      ||
                    dates_due[0].date.month    !== month_index      ||
                    dates_due[0].date.mday     !== day_of_month)
                begin
                    if (fault_count < SHOWN_FAULTS)
                    begin
                        $display("mismatch for stamp %0d: expected %s, got %s",
                                 dates_due[0].stamp, show_date(dates_due[0].date),
                                 show_date({second_of_minute, minute_of_hour, hour_of_day,
                                            day_of_week, years_since_1900, day_of_year,
                                            month_index, day_of_month}));
                    end
                    fault_count <= fault_count + 1;
                end
                void'(dates_due.pop_front());
            end
        end
    end

    // Watchdog. Any accepted word or result counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done === 1'b1)
            begin
                hang_count <= 0;
            end
            else if (hang_count >= HANG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
            begin
                hang_count <= hang_count + 1;
            end
        end
    end

    // Picks a random timestamp. Full-width values exercise every input bit and
    // the far future; 32-bit values keep most dates in a familiar range; the
    // rest pick a random day and often land on or next to a midnight.
    function automatic logic [STAMP_WIDTH-1:0] pick_stamp();
        int unsigned     kind;
        longint unsigned days;
        longint unsigned tod;
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            return {4'($urandom_range(0, 15)), 32'($urandom())};
        end
        if (kind < 65)
        begin
            return STAMP_WIDTH'($urandom());
        end
        days = $urandom_range(0, int'(DAY_COUNT_MAX) - 2);
        case ($urandom_range(0, 3))
            0: tod = 0;
            1: tod = SECS_IN_DAY - 1;
            2: tod = $urandom_range(0, 2);
            default: tod = $urandom_range(0, int'(SECS_IN_DAY) - 1);
        endcase
        return STAMP_WIDTH'(days * SECS_IN_DAY + tod);
    endfunction

    initial
    begin : stimulus
        logic [STAMP_WIDTH-1:0] directed[$];
        int unsigned            quiet_run;
        rst_n       = 1'b0;
        fault_count = 0;
        hang_count  = 0;
        quiet_run   = 0;

        // Field extremes and calendar corner cases: the epoch itself, the
        // rollover of each time-of-day field, the last day of an ordinary and
        // of a leap year, leap days, a century that is not a leap year, one
        // that is, the 2^31 and 2^32 marks and the largest input.
        directed = '{
            36'd0, 36'd1, 36'd59, 36'd60, 36'd3599, 36'd3600, 36'd86399, 36'd86400,
            36'd31535999, 36'd31536000, 36'd68169600, 36'd94608000, 36'd94694399,
            36'd946684799, 36'd951782400, 36'd951868800, 36'd2147483647, 36'd2147483648,
            36'd4107456000, 36'd4107542400, 36'd4294967295, 36'd4294967296,
            36'd13574563200, 36'd13601087999, {STAMP_WIDTH{1'b1}}
        };
        foreach (directed[i])
        begin
            stamps_waiting.push_back('{stamp: directed[i], hold: 1'b0, quiet: 1'b0});
        end
        // The first random word waits for the directed ones to drain completely.
        for (int unsigned n = 0; n < RANDOM_WORDS; n++)
        begin
            if (quiet_run == 0 && $urandom_range(0, 19) == 0)
            begin
                quiet_run = $urandom_range(10, 40);
            end
            stamps_waiting.push_back('{stamp: pick_stamp(),
                                       hold: (n == 0) || ($urandom_range(0, 199) == 0),
                                       quiet: quiet_run > 0});
            if (quiet_run > 0)
            begin
                quiet_run--;
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (stamps_waiting.size() > 0 || start || dates_due.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fault_count == 0 && dates_due.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
